// ===== rtl/prtbl_pkg.sv =====
// Package for the per-route token bucket limiter.
// Holds the controller states, the command and status structs and fixed constants.
// No dependencies.
package prtbl_pkg;

   localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
   localparam logic [23:0] COUNT_MAX  = 24'hFFFFFF;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DIV1,
      ST_PREP2,
      ST_DIV2,
      ST_REFILL,
      ST_TAKE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic clear_write;
      logic load;
      logic check;
      logic div_start_short;
      logic latch_interval;
      logic div_start_long;
      logic clear_add;
      logic latch_add;
      logic refill;
      logic take;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic limited;
      logic div_done;
      logic time_later;
   } status_type;

endpackage

// ===== rtl/prtbl_divider.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 30-bit divisor.
// Short run takes 30 steps (dividend in the top 30 bits), long run 64 steps.
// Depends on nothing.
module prtbl_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        short_run,
   input  logic [63:0] dividend,
   input  logic [29:0] divisor,
   output logic [63:0] quotient,
   output logic        done
);

   localparam logic [6:0] STEPS_LONG  = 7'd64;
   localparam logic [6:0] STEPS_SHORT = 7'd30;

   logic [29:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [29:0] div_ff;
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;

   logic [30:0] trial;
   logic [30:0] trial_sub;
   logic        ge;

   assign trial     = {rem_ff, quo_ff[63]};
   assign ge        = trial >= {1'b0, div_ff};
   assign trial_sub = trial - {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = short_run ? STEPS_SHORT : STEPS_LONG;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? trial_sub[29:0] : trial[29:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== rtl/prtbl_datapath.sv =====
// Datapath: request registers, per-route bucket memories, divider and refill logic.
// Depends on prtbl_pkg and prtbl_divider.
module prtbl_datapath #(
   parameter int unsigned ROUTES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  prtbl_pkg::cmd_type   cmd,
   output prtbl_pkg::status_type status,
   input  logic [5:0]           req_route_index,
   input  logic [63:0]          req_now_time,
   input  logic                 req_limit_enabled,
   input  logic [29:0]          req_rate_per_second,
   input  logic [23:0]          req_burst_size,
   output logic                 rsp_allowed
);

   localparam int unsigned AW = (ROUTES > 1) ? $clog2(ROUTES) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(ROUTES - 1);

   logic [23:0] token_mem [ROUTES];
   logic [63:0] time_mem  [ROUTES];

   logic [5:0]  route_ff;
   logic [63:0] now_ff;
   logic        enabled_ff;
   logic [29:0] rate_ff;
   logic [23:0] burst_ff;

   logic [AW-1:0] clr_ff, clr_in;
   logic [23:0]   cap_ff;
   logic [23:0]   cur_ff;
   logic [63:0]   old_ff;
   logic [29:0]   interval_ff;
   logic [63:0]   add_ff;
   logic [23:0]   count_ff;
   logic          refilled_ff;
   logic          allowed_ff;

   logic [31:0]   route_ext;
   logic [AW-1:0] addr;
   logic          in_range;
   logic          limited;
   logic [23:0]   cap_calc;

   logic          div_start;
   logic [63:0]   div_dividend;
   logic [29:0]   div_divisor;
   logic [63:0]   div_quotient;
   logic          div_done;

   logic [24:0]   refill_sum;
   logic [23:0]   refill_next;
   logic          refill_any;
   logic          take_ok;

   assign route_ext = {26'd0, route_ff};
   assign addr      = route_ext[AW-1:0];
   assign in_range  = route_ext < ROUTES;
   assign limited   = enabled_ff && (rate_ff != 30'd0) && in_range;
   assign cap_calc  = (burst_ff != 24'd0) ? burst_ff :
                      ((rate_ff > {6'd0, prtbl_pkg::COUNT_MAX}) ? prtbl_pkg::COUNT_MAX
                                                              : rate_ff[23:0]);

   assign div_start    = cmd.div_start_short | cmd.div_start_long;
   assign div_dividend = cmd.div_start_short ? {prtbl_pkg::NS_PER_SEC, 34'd0}
                                             : (now_ff - old_ff);
   assign div_divisor  = cmd.div_start_short ? rate_ff : interval_ff;

   prtbl_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .short_run (cmd.div_start_short),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quotient),
      .done      (div_done)
   );

   assign refill_any  = add_ff != 64'd0;
   assign refill_sum  = {1'b0, cur_ff} + {1'b0, add_ff[23:0]};
   assign refill_next = ((add_ff >= {40'd0, cap_ff}) || (refill_sum > {1'b0, cap_ff}))
                        ? cap_ff : refill_sum[23:0];
   assign take_ok     = count_ff != 24'd0;

   assign clr_in = cmd.clear_write ? clr_ff + AW'(1) : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         route_ff   <= req_route_index;
         now_ff     <= req_now_time;
         enabled_ff <= req_limit_enabled;
         rate_ff    <= req_rate_per_second;
         burst_ff   <= req_burst_size;
      end
      if (cmd.check) begin
         cap_ff     <= cap_calc;
         allowed_ff <= ~(enabled_ff && (rate_ff != 30'd0));
      end
      if (cmd.latch_interval) begin
         interval_ff <= (div_quotient[29:0] == 30'd0) ? 30'd1 : div_quotient[29:0];
      end
      if (cmd.clear_add) begin
         add_ff <= '0;
      end else if (cmd.latch_add) begin
         add_ff <= div_quotient;
      end
      if (cmd.refill) begin
         refilled_ff <= refill_any;
         count_ff    <= refill_any ? refill_next : cur_ff;
      end
      if (cmd.take) begin
         allowed_ff <= take_ok;
      end
   end

   // bucket memories: clearing pass, read on check, write back on take
   always_ff @(posedge clock) begin
      if (cmd.clear_write) begin
         token_mem[clr_ff] <= '0;
         time_mem[clr_ff]  <= '0;
      end else if (cmd.take) begin
         if (refilled_ff || take_ok) begin
            token_mem[addr] <= take_ok ? count_ff - 24'd1 : count_ff;
         end
         if (refilled_ff) begin
            time_mem[addr] <= now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.check && limited) begin
         cur_ff <= token_mem[addr];
         old_ff <= time_mem[addr];
      end
   end

   assign status.clear_last = clr_ff == LAST_ADDR;
   assign status.limited    = limited;
   assign status.div_done   = div_done;
   assign status.time_later = now_ff > old_ff;

   assign rsp_allowed = allowed_ff;

endmodule

// ===== rtl/prtbl_ctrl.sv =====
// Controller state machine sequencing clear, divisions, refill and take.
// Depends on prtbl_pkg.
module prtbl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  prtbl_pkg::status_type status,
   output prtbl_pkg::cmd_type    cmd,
   output logic                  busy,
   output logic                  rsp_valid
);

   prtbl_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prtbl_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = prtbl_pkg::ST_IDLE;
            end
         end
         prtbl_pkg::ST_IDLE: begin
            if (start) begin
               state_in = prtbl_pkg::ST_CHECK;
            end
         end
         prtbl_pkg::ST_CHECK: begin
            state_in = status.limited ? prtbl_pkg::ST_DIV1 : prtbl_pkg::ST_RESP;
         end
         prtbl_pkg::ST_DIV1: begin
            if (status.div_done) begin
               state_in = prtbl_pkg::ST_PREP2;
            end
         end
         prtbl_pkg::ST_PREP2: begin
            state_in = status.time_later ? prtbl_pkg::ST_DIV2 : prtbl_pkg::ST_REFILL;
         end
         prtbl_pkg::ST_DIV2: begin
            if (status.div_done) begin
               state_in = prtbl_pkg::ST_REFILL;
            end
         end
         prtbl_pkg::ST_REFILL: state_in = prtbl_pkg::ST_TAKE;
         prtbl_pkg::ST_TAKE:   state_in = prtbl_pkg::ST_RESP;
         prtbl_pkg::ST_RESP:   state_in = prtbl_pkg::ST_IDLE;
         default:              state_in = prtbl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         prtbl_pkg::ST_CLEAR: cmd.clear_write = 1'b1;
         prtbl_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         prtbl_pkg::ST_CHECK: begin
            cmd.check           = 1'b1;
            cmd.div_start_short = status.limited;
         end
         prtbl_pkg::ST_DIV1:  cmd.latch_interval = status.div_done;
         prtbl_pkg::ST_PREP2: begin
            cmd.div_start_long = status.time_later;
            cmd.clear_add      = ~status.time_later;
         end
         prtbl_pkg::ST_DIV2:   cmd.latch_add = status.div_done;
         prtbl_pkg::ST_REFILL: cmd.refill    = 1'b1;
         prtbl_pkg::ST_TAKE:   cmd.take      = 1'b1;
         prtbl_pkg::ST_RESP:   rsp_valid     = 1'b1;
         default:              cmd           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prtbl_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/per_route_token_bucket_limiter.sv =====
// Per-route token bucket admission check, one item at a time.
// An accepted item goes from CHECK to RESP when limiting is off or the route is out of range;
// otherwise the bit-serial divider finds the token interval (DIV1) and, if time has advanced,
// the refill count (DIV2), before REFILL, TAKE and RESP; the next item is accepted after RESP.
// Reset: busy for ROUTES cycles while the bucket memories are cleared.
// Results are strobed for one cycle; the receiver cannot stall.
module per_route_token_bucket_limiter #(
   parameter int unsigned ROUTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [5:0]  req_route_index,
   input  logic [63:0] req_now_time,
   input  logic        req_limit_enabled,
   input  logic [29:0] req_rate_per_second,
   input  logic [23:0] req_burst_size,
   output logic        rsp_valid,
   output logic        rsp_allowed
);

   prtbl_pkg::cmd_type    cmd;
   prtbl_pkg::status_type status;

   prtbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   prtbl_datapath #(
      .ROUTES (ROUTES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_route_index     (req_route_index),
      .req_now_time        (req_now_time),
      .req_limit_enabled   (req_limit_enabled),
      .req_rate_per_second (req_rate_per_second),
      .req_burst_size      (req_burst_size),
      .rsp_allowed         (rsp_allowed)
   );

endmodule
